>>> sv/ptm_pkg.sv
`default_nettype none
package ptm_pkg;

  localparam int COORD_BITS   = 12;
  localparam int UV_FRAC_BITS = 16;
  localparam int MAX_TEX_DIM  = 1024;

  localparam int UV_BITS   = 16;
  localparam int W_BITS    = 24;
  localparam int TEX_BITS  = $clog2(MAX_TEX_DIM);
  localparam int DIM_BITS  = TEX_BITS + 1;
  localparam int IDX_BITS  = 2 * TEX_BITS;
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int PROD_BITS = 2 * DIFF_BITS;
  localparam int EDGE_BITS = PROD_BITS + 3;
  localparam int EMAG_BITS = EDGE_BITS - 1;
  localparam int WT_FRAC   = 16;
  localparam int WT_BITS   = WT_FRAC + 1;
  localparam int RCP_BITS  = 33;
  localparam int UVW_BITS  = 32;
  localparam int ACC_BITS  = WT_BITS + RCP_BITS + 2;
  localparam int SCL_BITS  = ACC_BITS + DIM_BITS;
  localparam int DIV_DW    = ACC_BITS;
  localparam int DIV_QB    = RCP_BITS;

  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TEX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TEX_HEIGHT = 1'b1;
  localparam logic MODE_LOAD = 1'b0;
  localparam logic [1:0] SLOT_NONE = 2'd3;
  localparam logic [WT_BITS-1:0] WEIGHT_ONE = WT_BITS'(1 << WT_FRAC);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
  } pos_t;

  typedef struct packed {
    logic                         is_load;
    logic [1:0]                   slot;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic [UV_BITS-1:0]           u;
    logic [UV_BITS-1:0]           v;
    logic [W_BITS-1:0]            w;
  } item_t;

  typedef struct packed {
    logic                         is_load;
    logic [1:0]                   slot;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic [UV_BITS-1:0]           u;
    logic [UV_BITS-1:0]           v;
    logic [W_BITS-1:0]            w_eff;
    logic [EMAG_BITS-1:0]         area;
    logic [EMAG_BITS-1:0]         e0;
    logic [EMAG_BITS-1:0]         e1;
  } seg_t;

  typedef struct packed {
    pos_t                pos;
    logic [ACC_BITS-1:0] nu;
    logic [ACC_BITS-1:0] nv;
    logic [ACC_BITS-1:0] den;
  } acc_t;

  typedef struct packed {
    pos_t                pos;
    logic [TEX_BITS-1:0] col;
    logic [TEX_BITS-1:0] row;
    logic [IDX_BITS-1:0] idx;
  } res_t;

endpackage
`default_nettype wire

>>> sv/ptm_in_if.sv
`default_nettype none
interface ptm_in_if;
  import ptm_pkg::*;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [1:0]                   vertex_slot;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic [UV_BITS-1:0]           tex_u;
  logic [UV_BITS-1:0]           tex_v;
  logic [W_BITS-1:0]            persp_w;

  modport source (output valid, mode, vertex_slot, pos_x, pos_y, tex_u, tex_v, persp_w,
                  input ready);
  modport sink (input valid, mode, vertex_slot, pos_x, pos_y, tex_u, tex_v, persp_w,
                output ready);
endinterface
`default_nettype wire

>>> sv/ptm_out_if.sv
`default_nettype none
interface ptm_out_if;
  import ptm_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic [TEX_BITS-1:0]          texel_col;
  logic [TEX_BITS-1:0]          texel_row;
  logic [IDX_BITS-1:0]          texel_index;

  modport source (output valid, pixel_x, pixel_y, texel_col, texel_row, texel_index,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, texel_col, texel_row, texel_index,
                output ready);
endinterface
`default_nettype wire

>>> sv/ptm_div.sv
`default_nettype none
module ptm_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [ptm_pkg::DIV_DW-1:0]   rem_i,
  input  logic [ptm_pkg::DIV_QB-1:0]   lo_i,
  input  logic [ptm_pkg::DIV_DW-1:0]   den_i,
  output logic [ptm_pkg::DIV_QB-1:0]   quo_o
);
  import ptm_pkg::*;

  // one restoring step per stage; rem_i must be below den_i
  logic [DIV_DW-1:0] rem_r   [DIV_QB];
  logic [DIV_QB-1:0] lo_r    [DIV_QB];
  logic [DIV_DW-1:0] den_r   [DIV_QB];
  logic [DIV_QB-1:0] quo_r   [DIV_QB];
  logic [DIV_DW-1:0] rem_src [DIV_QB];
  logic [DIV_QB-1:0] lo_src  [DIV_QB];
  logic [DIV_DW-1:0] den_src [DIV_QB];
  logic [DIV_QB-1:0] quo_src [DIV_QB];
  logic [DIV_DW-1:0] rem_nxt [DIV_QB];
  logic [DIV_QB-1:0] quo_nxt [DIV_QB];

  always_comb begin
    logic [DIV_DW:0] sh;
    logic            fit;
    rem_src[0] = rem_i;
    lo_src[0]  = lo_i;
    den_src[0] = den_i;
    quo_src[0] = '0;
    for (int k = 1; k < DIV_QB; k++) begin
      rem_src[k] = rem_r[k-1];
      lo_src[k]  = lo_r[k-1];
      den_src[k] = den_r[k-1];
      quo_src[k] = quo_r[k-1];
    end
    for (int k = 0; k < DIV_QB; k++) begin
      sh  = {rem_src[k], lo_src[k][DIV_QB-1]};
      fit = (sh >= {1'b0, den_src[k]});
      rem_nxt[k] = fit ? DIV_DW'(sh - {1'b0, den_src[k]}) : sh[DIV_DW-1:0];
      quo_nxt[k] = {quo_src[k][DIV_QB-2:0], fit};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_QB; k++) begin
        rem_r[k] <= rem_nxt[k];
        lo_r[k]  <= {lo_src[k][DIV_QB-2:0], 1'b0};
        den_r[k] <= den_src[k];
        quo_r[k] <= quo_nxt[k];
      end
    end
  end

  assign quo_o = quo_r[DIV_QB-1];

endmodule
`default_nettype wire

>>> sv/ptm_edge.sv
`default_nettype none
module ptm_edge (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_vld,
  input  ptm_pkg::item_t in_item,
  output logic           seg_vld_o,
  output ptm_pkg::seg_t  seg_o
);
  import ptm_pkg::*;

  typedef struct packed {
    logic signed [DIFF_BITS-1:0] cax, cay, bax, bay, cpx, cpy, bpx, bpy, pax, pay;
  } dif_t;

  typedef struct packed {
    logic signed [PROD_BITS-1:0] p0, p1, p2, p3, p4, p5;
  } prd_t;

  function automatic logic signed [DIFF_BITS-1:0] dsub(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    return DIFF_BITS'(a) - DIFF_BITS'(b);
  endfunction

  item_t                       it_r [4];
  logic [3:0]                  v_r;
  logic signed [COORD_BITS-1:0] vx_r [3];
  logic signed [COORD_BITS-1:0] vy_r [3];
  dif_t                        dif_r, dif_nxt;
  prd_t                        prd_r, prd_nxt;
  logic signed [EDGE_BITS-1:0] area3_r, e03_r, e13_r;
  logic signed [EDGE_BITS-1:0] area3_nxt, e03_nxt, e13_nxt;
  logic signed [EDGE_BITS-1:0] e2, an, e0n, e1n, e2n;
  logic                        keep;
  seg_t                        seg_r, seg_nxt;
  logic                        seg_vld_r;

  always_comb begin
    dif_nxt.cax = dsub(vx_r[2], vx_r[0]);
    dif_nxt.cay = dsub(vy_r[2], vy_r[0]);
    dif_nxt.bax = dsub(vx_r[1], vx_r[0]);
    dif_nxt.bay = dsub(vy_r[1], vy_r[0]);
    dif_nxt.cpx = dsub(vx_r[2], it_r[0].px);
    dif_nxt.cpy = dsub(vy_r[2], it_r[0].py);
    dif_nxt.bpx = dsub(vx_r[1], it_r[0].px);
    dif_nxt.bpy = dsub(vy_r[1], it_r[0].py);
    dif_nxt.pax = dsub(it_r[0].px, vx_r[0]);
    dif_nxt.pay = dsub(it_r[0].py, vy_r[0]);
  end

  always_comb begin
    prd_nxt.p0 = $signed(dif_r.cax) * $signed(dif_r.bay);
    prd_nxt.p1 = $signed(dif_r.cay) * $signed(dif_r.bax);
    prd_nxt.p2 = $signed(dif_r.cpx) * $signed(dif_r.bpy);
    prd_nxt.p3 = $signed(dif_r.cpy) * $signed(dif_r.bpx);
    prd_nxt.p4 = $signed(dif_r.cax) * $signed(dif_r.pay);
    prd_nxt.p5 = $signed(dif_r.cay) * $signed(dif_r.pax);
  end

  always_comb begin
    area3_nxt = EDGE_BITS'($signed(prd_r.p0)) - EDGE_BITS'($signed(prd_r.p1));
    e03_nxt   = EDGE_BITS'($signed(prd_r.p2)) - EDGE_BITS'($signed(prd_r.p3));
    e13_nxt   = EDGE_BITS'($signed(prd_r.p4)) - EDGE_BITS'($signed(prd_r.p5));
  end

  // flip all signs for a clockwise triangle, then every edge must be non-negative
  always_comb begin
    e2   = area3_r - e03_r - e13_r;
    an   = area3_r[EDGE_BITS-1] ? -area3_r : area3_r;
    e0n  = area3_r[EDGE_BITS-1] ? -e03_r : e03_r;
    e1n  = area3_r[EDGE_BITS-1] ? -e13_r : e13_r;
    e2n  = area3_r[EDGE_BITS-1] ? -e2 : e2;
    keep = it_r[3].is_load ||
           (area3_r != '0 && !e0n[EDGE_BITS-1] && !e1n[EDGE_BITS-1] && !e2n[EDGE_BITS-1]);
    seg_nxt.is_load = it_r[3].is_load;
    seg_nxt.slot    = it_r[3].slot;
    seg_nxt.px      = it_r[3].px;
    seg_nxt.py      = it_r[3].py;
    seg_nxt.u       = it_r[3].u;
    seg_nxt.v       = it_r[3].v;
    seg_nxt.w_eff   = (it_r[3].w == '0) ? W_BITS'(1) : it_r[3].w;
    seg_nxt.area    = an[EMAG_BITS-1:0];
    seg_nxt.e0      = e0n[EMAG_BITS-1:0];
    seg_nxt.e1      = e1n[EMAG_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r       <= '0;
      seg_vld_r <= 1'b0;
    end else if (adv) begin
      v_r       <= {v_r[2:0], in_vld};
      seg_vld_r <= v_r[3] && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it_r[0] <= in_item;
      for (int k = 1; k < 4; k++) begin
        it_r[k] <= it_r[k-1];
      end
      dif_r   <= dif_nxt;
      prd_r   <= prd_nxt;
      area3_r <= area3_nxt;
      e03_r   <= e03_nxt;
      e13_r   <= e13_nxt;
      seg_r   <= seg_nxt;
      // positions are written and read at the same stage, so order holds
      if (v_r[0] && it_r[0].is_load && it_r[0].slot != SLOT_NONE) begin
        vx_r[it_r[0].slot] <= it_r[0].px;
        vy_r[it_r[0].slot] <= it_r[0].py;
      end
    end
  end

  assign seg_vld_o = seg_vld_r;
  assign seg_o     = seg_r;

  a_degenerate_drop: assert property (@(posedge clk) disable iff (!rst_n)
    adv && v_r[3] && !it_r[3].is_load && area3_r == '0 |=> !seg_vld_r)
    else $error("degenerate triangle let a pixel through");

endmodule
`default_nettype wire

>>> sv/ptm_interp.sv
`default_nettype none
module ptm_interp (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          seg_vld_i,
  input  ptm_pkg::seg_t seg_i,
  output logic          acc_vld_o,
  output ptm_pkg::acc_t acc_o
);
  import ptm_pkg::*;

  typedef struct packed {
    logic               is_load;
    logic [1:0]         slot;
    pos_t               pos;
    logic [UV_BITS-1:0] u;
    logic [UV_BITS-1:0] v;
  } side_t;

  localparam logic [DIV_QB-1:0] RCP_ONE = {1'b1, {(DIV_QB-1){1'b0}}};
  localparam int NUM_BITS = EMAG_BITS + WT_FRAC;

  logic [NUM_BITS-1:0] num0, num1;
  logic [DIV_QB-1:0]   q_wt0, q_wt1, q_rcp;
  side_t               side_in;
  side_t               sd_r [DIV_QB];
  logic [DIV_QB-1:0]   sv_r;
  side_t               sq;
  logic                vq;

  logic [RCP_BITS-1:0] rs_r [3];
  logic [UV_BITS-1:0]  us_r [3];
  logic [UV_BITS-1:0]  vs_r [3];

  logic [WT_BITS-1:0]          p1_wt_r [3], p1_wt_nxt [3];
  logic [UVW_BITS-1:0]         p1_uw_r [3], p1_uw_nxt [3];
  logic [UVW_BITS-1:0]         p1_vw_r [3], p1_vw_nxt [3];
  logic [RCP_BITS-1:0]         p1_rc_r [3];
  logic [WT_BITS+UVW_BITS-1:0] p2_nu_r [3], p2_nv_r [3];
  logic [WT_BITS+RCP_BITS-1:0] p2_dn_r [3];
  pos_t                        p1_pos_r, p2_pos_r;
  logic                        p1_v_r, p2_v_r, p3_v_r;
  acc_t                        acc_r;

  assign num0 = {seg_i.e0, {WT_FRAC{1'b0}}};
  assign num1 = {seg_i.e1, {WT_FRAC{1'b0}}};

  ptm_div u_wt0 (
    .clk   (clk),
    .en    (adv),
    .rem_i (DIV_DW'(num0 >> DIV_QB)),
    .lo_i  (num0[DIV_QB-1:0]),
    .den_i (DIV_DW'(seg_i.area)),
    .quo_o (q_wt0)
  );

  ptm_div u_wt1 (
    .clk   (clk),
    .en    (adv),
    .rem_i (DIV_DW'(num1 >> DIV_QB)),
    .lo_i  (num1[DIV_QB-1:0]),
    .den_i (DIV_DW'(seg_i.area)),
    .quo_o (q_wt1)
  );

  ptm_div u_rcp (
    .clk   (clk),
    .en    (adv),
    .rem_i ('0),
    .lo_i  (RCP_ONE),
    .den_i (DIV_DW'(seg_i.w_eff)),
    .quo_o (q_rcp)
  );

  always_comb begin
    side_in.is_load = seg_i.is_load;
    side_in.slot    = seg_i.slot;
    side_in.pos.px  = seg_i.px;
    side_in.pos.py  = seg_i.py;
    side_in.u       = seg_i.u;
    side_in.v       = seg_i.v;
  end

  assign sq = sd_r[DIV_QB-1];
  assign vq = sv_r[DIV_QB-1];

  always_comb begin
    logic [UV_BITS+RCP_BITS-1:0] mu, mv;
    p1_wt_nxt[0] = q_wt0[WT_BITS-1:0];
    p1_wt_nxt[1] = q_wt1[WT_BITS-1:0];
    p1_wt_nxt[2] = WEIGHT_ONE - q_wt0[WT_BITS-1:0] - q_wt1[WT_BITS-1:0];
    for (int i = 0; i < 3; i++) begin
      mu = us_r[i] * rs_r[i];
      mv = vs_r[i] * rs_r[i];
      p1_uw_nxt[i] = mu[UV_FRAC_BITS +: UVW_BITS];
      p1_vw_nxt[i] = mv[UV_FRAC_BITS +: UVW_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r   <= '0;
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
    end else if (adv) begin
      sv_r   <= {sv_r[DIV_QB-2:0], seg_vld_i};
      p1_v_r <= vq && !sq.is_load;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[0] <= side_in;
      for (int k = 1; k < DIV_QB; k++) begin
        sd_r[k] <= sd_r[k-1];
      end
      // vertex attributes land once the reciprocal is known; pixels read here too
      if (vq && sq.is_load && sq.slot != SLOT_NONE) begin
        rs_r[sq.slot] <= q_rcp;
        us_r[sq.slot] <= sq.u;
        vs_r[sq.slot] <= sq.v;
      end
      p1_pos_r <= sq.pos;
      p2_pos_r <= p1_pos_r;
      for (int i = 0; i < 3; i++) begin
        p1_wt_r[i] <= p1_wt_nxt[i];
        p1_uw_r[i] <= p1_uw_nxt[i];
        p1_vw_r[i] <= p1_vw_nxt[i];
        p1_rc_r[i] <= rs_r[i];
        p2_nu_r[i] <= p1_wt_r[i] * p1_uw_r[i];
        p2_nv_r[i] <= p1_wt_r[i] * p1_vw_r[i];
        p2_dn_r[i] <= p1_wt_r[i] * p1_rc_r[i];
      end
      acc_r.pos <= p2_pos_r;
      acc_r.nu  <= ACC_BITS'(p2_nu_r[0]) + ACC_BITS'(p2_nu_r[1]) + ACC_BITS'(p2_nu_r[2]);
      acc_r.nv  <= ACC_BITS'(p2_nv_r[0]) + ACC_BITS'(p2_nv_r[1]) + ACC_BITS'(p2_nv_r[2]);
      acc_r.den <= ACC_BITS'(p2_dn_r[0]) + ACC_BITS'(p2_dn_r[1]) + ACC_BITS'(p2_dn_r[2]);
    end
  end

  assign acc_vld_o = p3_v_r;
  assign acc_o     = acc_r;

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vq && sq.is_load |=> !p1_v_r)
    else $error("vertex load continued as a pixel");

endmodule
`default_nettype wire

>>> sv/ptm_tex.sv
`default_nettype none
module ptm_tex (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          acc_vld_i,
  input  ptm_pkg::acc_t                 acc_i,
  input  logic [ptm_pkg::DIM_BITS-1:0]  wdim_i,
  input  logic [ptm_pkg::DIM_BITS-1:0]  hdim_i,
  output logic                          res_vld_o,
  output ptm_pkg::res_t                 res_o
);
  import ptm_pkg::*;

  logic [SCL_BITS-1:0] sn_r, sm_r;
  logic [ACC_BITS-1:0] den_r;
  pos_t                t0_pos_r;
  logic                t0_v_r;
  logic [DIV_QB-1:0]   q_col, q_row;
  pos_t                pos_r [DIV_QB];
  logic [DIV_QB-1:0]   sv_r;
  logic [DIM_BITS-1:0] wm1, hm1;
  logic [TEX_BITS-1:0] col_nxt, row_nxt;
  logic [TEX_BITS-1:0] c1_col_r, c1_row_r;
  pos_t                c1_pos_r;
  logic                c1_v_r;
  res_t                res_r;
  logic                res_v_r;

  ptm_div u_col (
    .clk   (clk),
    .en    (adv),
    .rem_i (DIV_DW'(sn_r >> DIV_QB)),
    .lo_i  (sn_r[DIV_QB-1:0]),
    .den_i (den_r),
    .quo_o (q_col)
  );

  ptm_div u_row (
    .clk   (clk),
    .en    (adv),
    .rem_i (DIV_DW'(sm_r >> DIV_QB)),
    .lo_i  (sm_r[DIV_QB-1:0]),
    .den_i (den_r),
    .quo_o (q_row)
  );

  // clamp to the last texel of each axis
  always_comb begin
    wm1     = wdim_i - DIM_BITS'(1);
    hm1     = hdim_i - DIM_BITS'(1);
    col_nxt = (q_col > DIV_QB'(wm1)) ? wm1[TEX_BITS-1:0] : q_col[TEX_BITS-1:0];
    row_nxt = (q_row > DIV_QB'(hm1)) ? hm1[TEX_BITS-1:0] : q_row[TEX_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_v_r  <= 1'b0;
      sv_r    <= '0;
      c1_v_r  <= 1'b0;
      res_v_r <= 1'b0;
    end else if (adv) begin
      t0_v_r  <= acc_vld_i;
      sv_r    <= {sv_r[DIV_QB-2:0], t0_v_r};
      c1_v_r  <= sv_r[DIV_QB-1];
      res_v_r <= c1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sn_r     <= acc_i.nu * wdim_i;
      sm_r     <= acc_i.nv * hdim_i;
      den_r    <= acc_i.den;
      t0_pos_r <= acc_i.pos;
      pos_r[0] <= t0_pos_r;
      for (int k = 1; k < DIV_QB; k++) begin
        pos_r[k] <= pos_r[k-1];
      end
      c1_col_r  <= col_nxt;
      c1_row_r  <= row_nxt;
      c1_pos_r  <= pos_r[DIV_QB-1];
      res_r.pos <= c1_pos_r;
      res_r.col <= c1_col_r;
      res_r.row <= c1_row_r;
      res_r.idx <= IDX_BITS'(c1_row_r * wdim_i + (TEX_BITS+DIM_BITS)'(c1_col_r));
    end
  end

  assign res_vld_o = res_v_r;
  assign res_o     = res_r;

  a_div_continuity: assert property (@(posedge clk) disable iff (!rst_n)
    adv && sv_r[DIV_QB-1] |=> c1_v_r)
    else $error("pixel lost after texel divide");

endmodule
`default_nettype wire

>>> sv/perspective_texel_mapper.sv
`default_nettype none
// Throughput: one word per cycle; the 33-stage restoring dividers for weights,
// reciprocal w and texel scaling are fully pipelined, and a stall freezes all stages.
// Loads, outside pixels and degenerate triangles travel the pipe but give no result.
// Reset (synchronous, rst_n low): pipeline emptied, texture size back to 64 x 64;
// vertex stores are not cleared and hold nothing valid until loaded.
module perspective_texel_mapper (
  input  logic                              clk,
  input  logic                              rst_n,
  ptm_in_if.sink                            in_ch,
  ptm_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [ptm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [ptm_pkg::DIM_BITS-1:0]      cfg_data
);
  import ptm_pkg::*;

  function automatic logic [DIM_BITS-1:0] eff_dim(input logic [DIM_BITS-1:0] d);
    if (d == '0) begin
      return DIM_BITS'(1);
    end else if (d > DIM_BITS'(MAX_TEX_DIM)) begin
      return DIM_BITS'(MAX_TEX_DIM);
    end else begin
      return d;
    end
  endfunction

  logic [DIM_BITS-1:0] tex_width_r, tex_height_r;
  logic [DIM_BITS-1:0] wdim, hdim;
  logic                adv;
  item_t               in_item;
  logic                seg_vld;
  seg_t                seg;
  logic                acc_vld;
  acc_t                acc;
  logic                tx_vld;
  res_t                tx_res;
  logic                out_valid_r;
  res_t                out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r  <= DIM_BITS'(64);
      tex_height_r <= DIM_BITS'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEX_WIDTH:  tex_width_r  <= cfg_data;
        REG_TEX_HEIGHT: tex_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign wdim = eff_dim(tex_width_r);
  assign hdim = eff_dim(tex_height_r);

  // advance unless a finished word is stuck behind a full output register
  assign adv         = !tx_vld || !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_comb begin
    in_item.is_load = (in_ch.mode == MODE_LOAD);
    in_item.slot    = in_ch.vertex_slot;
    in_item.px      = in_ch.pos_x;
    in_item.py      = in_ch.pos_y;
    in_item.u       = in_ch.tex_u;
    in_item.v       = in_ch.tex_v;
    in_item.w       = in_ch.persp_w;
  end

  ptm_edge u_edge (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_vld    (in_ch.valid),
    .in_item   (in_item),
    .seg_vld_o (seg_vld),
    .seg_o     (seg)
  );

  ptm_interp u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .seg_vld_i (seg_vld),
    .seg_i     (seg),
    .acc_vld_o (acc_vld),
    .acc_o     (acc)
  );

  ptm_tex u_tex (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .acc_vld_i (acc_vld),
    .acc_i     (acc),
    .wdim_i    (wdim),
    .hdim_i    (hdim),
    .res_vld_o (tx_vld),
    .res_o     (tx_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= tx_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ch.ready) begin
      out_res_r <= tx_res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_x     = out_res_r.pos.px;
  assign out_ch.pixel_y     = out_res_r.pos.py;
  assign out_ch.texel_col   = out_res_r.col;
  assign out_ch.texel_row   = out_res_r.row;
  assign out_ch.texel_index = out_res_r.idx;

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(tx_vld))
    else $error("result word appeared without a finished pixel");

endmodule
`default_nettype wire
